// File: hdl/bfmd_pkg.sv
// Shared types and constants for the 2x2 box-filter mip level generator.
package bfmd_pkg;

    localparam int CFG_BITS    = 12;
    localparam int ROW_BITS    = 11;
    localparam int HEIGHT_BITS = 12;
    localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT = 12'd2048;

    typedef enum logic
    {
        REG_SOURCE_WIDTH  = 1'b0,
        REG_SOURCE_HEIGHT = 1'b1
    } bfmd_reg_t;

    // Per-word control that rides along the pipeline.
    typedef struct packed
    {
        logic store_write;
        logic store_read;
        logic row_end;
        logic image_end;
    } bfmd_flags_t;

endpackage

// File: hdl/bfmd_ctrl.sv
// Raster counters, pixel pairing and the first pipeline register.
module bfmd_ctrl
    import bfmd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr,
    input  logic [CFG_BITS-1:0]     source_width,
    input  logic [CFG_BITS-1:0]     source_height,
    input  logic                    pixel_fire,
    input  logic [PIXEL_BITS-1:0]   pixel_value,
    input  logic                    adv,
    output logic                    a_valid,
    output bfmd_flags_t             a_flags,
    output logic [((MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] a_slot,
    output logic [PIXEL_BITS:0]     a_pair
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int AW = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;

    logic [LW-1:0]          w_ext;
    logic [CW-1:0]          w;
    logic [HEIGHT_BITS-1:0] h;
    logic [XW-1:0]          x_reg, x_next;
    logic [ROW_BITS-1:0]    y_reg, y_next;
    logic [CW-1:0]          xe;
    logic [HEIGHT_BITS-1:0] ye;
    logic                   x_wrap, y_wrap;
    logic                   mode_2d, mode_v, mode_h;
    logic                   col_in, row_in, last_col, last_row;
    logic                   active, second, hold, pair_go;
    bfmd_flags_t            flags;
    logic [PIXEL_BITS-1:0]  held_reg;
    logic                   a_valid_reg;
    bfmd_flags_t            a_flags_reg;
    logic [AW-1:0]          a_slot_reg;
    logic [PIXEL_BITS:0]    a_pair_reg;

    // Out-of-range sizes are clamped; zero counts as one.
    assign w_ext = LW'(source_width);
    assign w = (source_width == '0) ? CW'(1)
             : (w_ext > LW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_ext);
    assign h = (source_height == '0) ? HEIGHT_BITS'(1)
             : (source_height > MAX_HEIGHT) ? MAX_HEIGHT : source_height;

    assign xe = CW'(x_reg);
    assign ye = HEIGHT_BITS'(y_reg);

    assign x_wrap = (xe + CW'(1)) >= w;
    assign y_wrap = (ye + HEIGHT_BITS'(1)) >= h;

    assign mode_2d = (w > CW'(1)) && (h > HEIGHT_BITS'(1));
    assign mode_v  = (w == CW'(1)) && (h > HEIGHT_BITS'(1));
    assign mode_h  = (w > CW'(1)) && (h == HEIGHT_BITS'(1));

    // An odd last column or row is dropped.
    assign col_in = !(w[0] && (xe == w - CW'(1)));
    assign row_in = !(h[0] && (ye == h - HEIGHT_BITS'(1)));

    assign last_col = w[0] ? (xe == w - CW'(2)) : (xe == w - CW'(1));
    assign last_row = h[0] ? (ye == h - HEIGHT_BITS'(2)) : (ye == h - HEIGHT_BITS'(1));

    always_comb
    begin
        priority if (mode_2d)
            active = col_in && row_in;
        else if (mode_v)
            active = row_in;
        else if (mode_h)
            active = col_in;
        else
            active = 1'b0;
    end

    assign second  = mode_v ? y_reg[0] : x_reg[0];
    assign hold    = active && !second;
    assign pair_go = active && second;

    always_comb
    begin
        flags.store_write = mode_2d && !y_reg[0];
        flags.store_read  = mode_2d && y_reg[0];
        flags.row_end     = mode_v ? 1'b1 : last_col;
        if (mode_v)
            flags.image_end = last_row;
        else if (mode_h)
            flags.image_end = last_col;
        else
            flags.image_end = last_col && last_row;
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cfg_wr)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (pixel_fire)
        begin
            if (x_wrap)
            begin
                x_next = '0;
                y_next = y_wrap ? '0 : y_reg + ROW_BITS'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            held_reg    <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (pixel_fire && hold)
                held_reg <= pixel_value;
            if (adv)
                a_valid_reg <= pixel_fire && pair_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && pixel_fire)
        begin
            a_flags_reg <= flags;
            a_slot_reg  <= AW'(x_reg >> 1);
            a_pair_reg  <= (PIXEL_BITS + 1)'(held_reg) + (PIXEL_BITS + 1)'(pixel_value);
        end
    end

    assign a_valid = a_valid_reg;
    assign a_flags = a_flags_reg;
    assign a_slot  = a_slot_reg;
    assign a_pair  = a_pair_reg;

endmodule

// File: hdl/bfmd_store.sv
// Line store of even-row pair sums and the second pipeline register.
module bfmd_store
    import bfmd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    a_valid,
    input  bfmd_flags_t             a_flags,
    input  logic [((MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] a_slot,
    input  logic [PIXEL_BITS:0]     a_pair,
    output logic                    b_valid,
    output bfmd_flags_t             b_flags,
    output logic [PIXEL_BITS:0]     b_pair,
    output logic [PIXEL_BITS:0]     b_above
);

    localparam int DEPTH = MAX_WIDTH / 2;

    logic [PIXEL_BITS:0] line_mem [DEPTH];
    logic                b_valid_reg;
    bfmd_flags_t         b_flags_reg;
    logic [PIXEL_BITS:0] b_pair_reg;
    logic [PIXEL_BITS:0] b_above_reg;

    // Even-row words only write the store; they leave the pipeline here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid && !a_flags.store_write;
    end

    always_ff @(posedge clk)
    begin
        if (adv && a_valid && a_flags.store_write)
            line_mem[a_slot] <= a_pair;
        if (adv && a_valid && a_flags.store_read)
            b_above_reg <= line_mem[a_slot];
        if (adv && a_valid)
        begin
            b_flags_reg <= a_flags;
            b_pair_reg  <= a_pair;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_flags = b_flags_reg;
    assign b_pair  = b_pair_reg;
    assign b_above = b_above_reg;

endmodule

// File: hdl/bfmd_avg.sv
// Final averaging and the result register.
module bfmd_avg
    import bfmd_pkg::*;
#(
    parameter int PIXEL_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  b_valid,
    input  bfmd_flags_t           b_flags,
    input  logic [PIXEL_BITS:0]   b_pair,
    input  logic [PIXEL_BITS:0]   b_above,
    output logic                  out_valid,
    output logic [PIXEL_BITS-1:0] out_value,
    output logic                  out_row_end,
    output logic                  out_image_end
);

    logic [PIXEL_BITS+1:0]  quad_sum;
    logic [PIXEL_BITS-1:0]  avg_value;
    logic                   out_valid_reg;
    logic [PIXEL_BITS-1:0]  out_value_reg;
    logic                   out_row_end_reg;
    logic                   out_image_end_reg;

    assign quad_sum  = (PIXEL_BITS + 2)'(b_above) + (PIXEL_BITS + 2)'(b_pair);
    assign avg_value = b_flags.store_read ? PIXEL_BITS'(quad_sum >> 2)
                                          : PIXEL_BITS'(b_pair >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid)
        begin
            out_value_reg     <= avg_value;
            out_row_end_reg   <= b_flags.row_end;
            out_image_end_reg <= b_flags.image_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_row_end   = out_row_end_reg;
    assign out_image_end = out_image_end_reg;

endmodule

// File: hdl/box_filter_mipmap_downscaler.sv
// Top level of the 2x2 box-filter mip level generator with its register port.
//
// Takes one source pixel per clock in raster order while pixel_ready is high and
// returns one mip pixel per completed 2x2 block (or pair, for one-wide or one-row
// images). Each word passes a pairing register and a line-store access register,
// and a word that yields a mip pixel also a result register, each with its own
// valid bit, so a new pixel is taken in every cycle while the result register is
// free or being emptied. The line store holds MAX_WIDTH/2 pair sums in a memory with
// one write and one registered read per cycle; it is never cleared, since an odd row
// only reads sums left by the even row above it. Width and height live at byte
// addresses 0 and 4; writing either one restarts the image at its top-left pixel.
module box_filter_mipmap_downscaler
    import bfmd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    output logic                  mip_valid,
    input  logic                  mip_ready,
    output logic [PIXEL_BITS-1:0] mip_value,
    output logic                  row_end,
    output logic                  image_end
);

    localparam int AW = (MAX_WIDTH >= 4) ? $clog2(MAX_WIDTH / 2) : 1;

    logic [CFG_BITS-1:0] source_width_reg;
    logic [CFG_BITS-1:0] source_height_reg;
    bfmd_reg_t           reg_sel;
    logic                cfg_wr;
    logic                en_a, en_b, en_c;
    logic                pixel_fire;
    logic                a_valid, b_valid;
    bfmd_flags_t         a_flags, b_flags;
    logic [AW-1:0]       a_slot;
    logic [PIXEL_BITS:0] a_pair, b_pair, b_above;

    assign reg_sel = bfmd_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= CFG_BITS'(1);
            source_height_reg <= CFG_BITS'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_SOURCE_WIDTH:  source_width_reg  <= pwdata[CFG_BITS-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= pwdata[CFG_BITS-1:0];
                default:           source_width_reg  <= source_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SOURCE_WIDTH:  prdata = 32'(source_width_reg);
            REG_SOURCE_HEIGHT: prdata = 32'(source_height_reg);
            default:           prdata = '0;
        endcase
    end

    // Each stage moves when it is empty or the one after it is moving.
    assign en_c        = !mip_valid || mip_ready;
    assign en_b        = !b_valid || en_c;
    assign en_a        = !a_valid || en_b;
    assign pixel_ready = en_a;
    assign pixel_fire  = pixel_valid && en_a;

    bfmd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_wr),
        .source_width  (source_width_reg),
        .source_height (source_height_reg),
        .pixel_fire    (pixel_fire),
        .pixel_value   (pixel_value),
        .adv           (en_a),
        .a_valid       (a_valid),
        .a_flags       (a_flags),
        .a_slot        (a_slot),
        .a_pair        (a_pair)
    );

    bfmd_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (en_b),
        .a_valid (a_valid),
        .a_flags (a_flags),
        .a_slot  (a_slot),
        .a_pair  (a_pair),
        .b_valid (b_valid),
        .b_flags (b_flags),
        .b_pair  (b_pair),
        .b_above (b_above)
    );

    bfmd_avg #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_avg (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (en_c),
        .b_valid       (b_valid),
        .b_flags       (b_flags),
        .b_pair        (b_pair),
        .b_above       (b_above),
        .out_valid     (mip_valid),
        .out_value     (mip_value),
        .out_row_end   (row_end),
        .out_image_end (image_end)
    );

endmodule
